// ===== src/bis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_pkg
// Shared constants, register codes, configuration type and sizing helpers
// for the bilinear image scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

    // Default sizing, handed to the top-level parameters
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int FRAC_BITS_DEF  = 16;

    // Fixed field widths
    localparam int COORD_W = 8;
    localparam int PIX_W   = 8;
    localparam int SIZE_W  = 9;
    localparam int RATIO_W = 25;
    localparam int PROD_W  = COORD_W + RATIO_W;

    // Configuration port
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_H_RATIO    = 2'd2;
    localparam logic [1:0] REG_V_RATIO    = 2'd3;

    // Register reset values; a ratio of 1.0 in Q9.16
    localparam logic [SIZE_W-1:0]  SIZE_RST  = 9'd256;
    localparam logic [RATIO_W-1:0] RATIO_RST = 25'h001_0000;

    // Item kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [SIZE_W-1:0]  src_width;
        logic [SIZE_W-1:0]  src_height;
        logic [RATIO_W-1:0] h_ratio;
        logic [RATIO_W-1:0] v_ratio;
    } cfg_t;

    // Index width that never collapses to zero bits
    function automatic int clog2_min1(input int n);
        return (n <= 2) ? 1 : $clog2(n);
    endfunction

    // Entries of one parity bank along one axis
    function automatic int half_of(input int n);
        return (n + 1) / 2;
    endfunction

    // Bits of one queue entry: kind, ix, iy, fx, fy, x, y, pixel
    function automatic int entry_width(input int max_w, input int max_h, input int frac);
        return 1 + clog2_min1(max_w) + clog2_min1(max_h) + 2 * frac
               + 2 * COORD_W + PIX_W;
    endfunction

endpackage

// ===== src/bis_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_if
// Valid/ready channels of the scaler: item channel and result channel.
// ----------------------------------------------------------------------------
interface bis_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [bis_pkg::COORD_W-1:0]  pos_x;
    logic [bis_pkg::COORD_W-1:0]  pos_y;
    logic [bis_pkg::PIX_W-1:0]    pixel_in;

    modport source (output valid, kind, pos_x, pos_y, pixel_in, input ready);
    modport sink   (input valid, kind, pos_x, pos_y, pixel_in, output ready);
endinterface

interface bis_out_if;
    logic                         valid;
    logic                         ready;
    logic [bis_pkg::COORD_W-1:0]  out_x;
    logic [bis_pkg::COORD_W-1:0]  out_y;
    logic [bis_pkg::PIX_W-1:0]    out_value;

    modport source (output valid, out_x, out_y, out_value, input ready);
    modport sink   (input valid, out_x, out_y, out_value, output ready);
endinterface

// ===== src/bis_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_ram
// Generic single-port RAM with registered read; read data holds when idle.
// ----------------------------------------------------------------------------
module bis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic                                   re,
    input  logic [bis_pkg::clog2_min1(DEPTH)-1:0]  addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on we, capture read data on re
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/bis_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_cfg
// APB register file: source size and the two scaling ratios.
// ----------------------------------------------------------------------------
module bis_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bis_pkg::CFG_AW-1:0]   paddr,
    input  logic [bis_pkg::CFG_DW-1:0]   pwdata,
    output logic [bis_pkg::CFG_DW-1:0]   prdata,
    output logic                         pready,
    output bis_pkg::cfg_t                cfg
);

    bis_pkg::cfg_t cfg_reg;
    bis_pkg::cfg_t cfg_next;
    logic [1:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Decode the write beat
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                bis_pkg::REG_SRC_WIDTH:  cfg_next.src_width  = pwdata[bis_pkg::SIZE_W-1:0];
                bis_pkg::REG_SRC_HEIGHT: cfg_next.src_height = pwdata[bis_pkg::SIZE_W-1:0];
                bis_pkg::REG_H_RATIO:    cfg_next.h_ratio    = pwdata[bis_pkg::RATIO_W-1:0];
                bis_pkg::REG_V_RATIO:    cfg_next.v_ratio    = pwdata[bis_pkg::RATIO_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width  <= bis_pkg::SIZE_RST;
            cfg_reg.src_height <= bis_pkg::SIZE_RST;
            cfg_reg.h_ratio    <= bis_pkg::RATIO_RST;
            cfg_reg.v_ratio    <= bis_pkg::RATIO_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_idx)
            bis_pkg::REG_SRC_WIDTH:  prdata = bis_pkg::CFG_DW'(cfg_reg.src_width);
            bis_pkg::REG_SRC_HEIGHT: prdata = bis_pkg::CFG_DW'(cfg_reg.src_height);
            bis_pkg::REG_H_RATIO:    prdata = bis_pkg::CFG_DW'(cfg_reg.h_ratio);
            bis_pkg::REG_V_RATIO:    prdata = bis_pkg::CFG_DW'(cfg_reg.v_ratio);
            default:                 prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/bis_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_front
// Accept items, scale sample coordinates by the ratios, clamp at the right
// and bottom edges and push loads and samples into the queue in order.
// ----------------------------------------------------------------------------
module bis_front #(
    parameter int MAX_WIDTH  = bis_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bis_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = bis_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    bis_in_if.sink        items,
    input  bis_pkg::cfg_t cfg,
    input  logic          q_full,
    output logic          push,
    output logic [bis_pkg::entry_width(MAX_WIDTH, MAX_HEIGHT, FRAC_BITS)-1:0] push_data
);

    localparam int COL_W  = bis_pkg::clog2_min1(MAX_WIDTH);
    localparam int ROW_W  = bis_pkg::clog2_min1(MAX_HEIGHT);
    localparam int SZW_W  = $clog2(MAX_WIDTH + 1);
    localparam int SZH_W  = $clog2(MAX_HEIGHT + 1);
    localparam int IP_W   = bis_pkg::PROD_W - FRAC_BITS;
    localparam int CMPX_W = ((IP_W > SZW_W) ? IP_W : SZW_W) + 1;
    localparam int CMPY_W = ((IP_W > SZH_W) ? IP_W : SZH_W) + 1;

    typedef struct packed {
        logic                         is_sample;
        logic [COL_W-1:0]             ix;
        logic [ROW_W-1:0]             iy;
        logic [FRAC_BITS-1:0]         fx;
        logic [FRAC_BITS-1:0]         fy;
        logic [bis_pkg::COORD_W-1:0]  pos_x;
        logic [bis_pkg::COORD_W-1:0]  pos_y;
        logic [bis_pkg::PIX_W-1:0]    pixel;
    } entry_t;

    logic                         f1_valid_reg, f1_valid_next;
    logic                         f1_kind_reg;
    logic [bis_pkg::COORD_W-1:0]  f1_x_reg, f1_y_reg;
    logic [bis_pkg::PIX_W-1:0]    f1_pix_reg;
    logic [bis_pkg::PROD_W-1:0]   f1_px_reg, f1_py_reg;
    logic [bis_pkg::PROD_W-1:0]   px_next, py_next;

    logic                         accept;
    logic                         keep;
    logic                         leave;
    logic [SZW_W-1:0]             eff_w;
    logic [SZH_W-1:0]             eff_h;
    logic [IP_W-1:0]              ip_x, ip_y;
    logic                         edge_x, edge_y;
    logic [COL_W-1:0]             samp_ix;
    logic [ROW_W-1:0]             samp_iy;
    entry_t                       entry;

    // Scale the destination coordinates on the way in
    assign px_next = bis_pkg::PROD_W'(items.pos_x) * bis_pkg::PROD_W'(cfg.h_ratio);
    assign py_next = bis_pkg::PROD_W'(items.pos_y) * bis_pkg::PROD_W'(cfg.v_ratio);

    // Saturate the source size into 2 .. MAX
    always_comb
    begin
        priority if (32'(cfg.src_width) < 32'd2)
            eff_w = SZW_W'(2);
        else if (32'(cfg.src_width) > 32'(MAX_WIDTH))
            eff_w = SZW_W'(MAX_WIDTH);
        else
            eff_w = SZW_W'(cfg.src_width);

        priority if (32'(cfg.src_height) < 32'd2)
            eff_h = SZH_W'(2);
        else if (32'(cfg.src_height) > 32'(MAX_HEIGHT))
            eff_h = SZH_W'(MAX_HEIGHT);
        else
            eff_h = SZH_W'(cfg.src_height);
    end

    // Split into integer and fraction, pull back from the far edge
    assign ip_x    = f1_px_reg[bis_pkg::PROD_W-1:FRAC_BITS];
    assign ip_y    = f1_py_reg[bis_pkg::PROD_W-1:FRAC_BITS];
    assign edge_x  = (CMPX_W'(ip_x) + CMPX_W'(1)) >= CMPX_W'(eff_w);
    assign edge_y  = (CMPY_W'(ip_y) + CMPY_W'(1)) >= CMPY_W'(eff_h);
    assign samp_ix = edge_x ? COL_W'(eff_w - SZW_W'(2)) : COL_W'(ip_x);
    assign samp_iy = edge_y ? ROW_W'(eff_h - SZH_W'(2)) : ROW_W'(ip_y);

    // Build the queue entry
    always_comb
    begin
        entry.is_sample = (f1_kind_reg == bis_pkg::KIND_SAMPLE);
        entry.ix        = entry.is_sample ? samp_ix : COL_W'(f1_x_reg);
        entry.iy        = entry.is_sample ? samp_iy : ROW_W'(f1_y_reg);
        entry.fx        = f1_px_reg[FRAC_BITS-1:0];
        entry.fy        = f1_py_reg[FRAC_BITS-1:0];
        entry.pos_x     = f1_x_reg;
        entry.pos_y     = f1_y_reg;
        entry.pixel     = f1_pix_reg;
    end

    // Drop loads that fall outside the store
    assign keep = entry.is_sample
                  || ((32'(f1_x_reg) < 32'(MAX_WIDTH)) && (32'(f1_y_reg) < 32'(MAX_HEIGHT)));

    assign leave       = f1_valid_reg && (!keep || !q_full);
    assign push        = f1_valid_reg && keep && !q_full;
    assign push_data   = entry;
    assign items.ready = !f1_valid_reg || leave;
    assign accept      = items.valid && items.ready;

    always_comb
    begin
        f1_valid_next = f1_valid_reg;
        if (accept)
        begin
            f1_valid_next = 1'b1;
        end
        else if (leave)
        begin
            f1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= f1_valid_next;
        end
    end

    // Hold the beat's payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_kind_reg <= items.kind;
            f1_x_reg    <= items.pos_x;
            f1_y_reg    <= items.pos_y;
            f1_pix_reg  <= items.pixel_in;
            f1_px_reg   <= px_next;
            f1_py_reg   <= py_next;
        end
    end

endmodule

// ===== src/bis_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_queue
// Short FIFO between the front and the back of the scaler.
// ----------------------------------------------------------------------------
module bis_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bis_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = bis_pkg::clog2_min1(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = store_reg[rd_ptr_reg];

    // Advance pointers with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/bis_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_back
// Frame store in four row/column parity banks. Loads write one bank; samples
// read all four neighbours at once, then weight, multiply and sum them in a
// pipeline that stalls as a whole on the result register.
// ----------------------------------------------------------------------------
module bis_back #(
    parameter int MAX_WIDTH  = bis_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bis_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = bis_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  logic [bis_pkg::entry_width(MAX_WIDTH, MAX_HEIGHT, FRAC_BITS)-1:0] head,
    output logic          pop,
    bis_out_if.source     results
);

    localparam int COL_W      = bis_pkg::clog2_min1(MAX_WIDTH);
    localparam int ROW_W      = bis_pkg::clog2_min1(MAX_HEIGHT);
    localparam int HALF_W     = bis_pkg::half_of(MAX_WIDTH);
    localparam int HALF_H     = bis_pkg::half_of(MAX_HEIGHT);
    localparam int CH_W       = bis_pkg::clog2_min1(HALF_W);
    localparam int RH_W       = bis_pkg::clog2_min1(HALF_H);
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int BANK_AW    = bis_pkg::clog2_min1(BANK_DEPTH);
    localparam int WT_W       = 2 * FRAC_BITS + 2;
    localparam int PR_W       = WT_W + bis_pkg::PIX_W;
    localparam int SUM_W      = PR_W + 2;
    localparam int SHIFT      = 2 * FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef struct packed {
        logic                         is_sample;
        logic [COL_W-1:0]             ix;
        logic [ROW_W-1:0]             iy;
        logic [FRAC_BITS-1:0]         fx;
        logic [FRAC_BITS-1:0]         fy;
        logic [bis_pkg::COORD_W-1:0]  pos_x;
        logic [bis_pkg::COORD_W-1:0]  pos_y;
        logic [bis_pkg::PIX_W-1:0]    pixel;
    } entry_t;

    entry_t                      head_e;
    logic                        adv;
    logic [RH_W-1:0]             rh0, rh1;
    logic [CH_W-1:0]             ch0, ch1;
    logic [BANK_AW-1:0]          bank_addr [4];
    logic [3:0]                  bank_we;
    logic                        bank_re;
    logic [bis_pkg::PIX_W-1:0]   rd_data [4];

    // Stage 1: read data arrives from the banks
    logic                        s1_valid_reg, s1_valid_next;
    logic [bis_pkg::COORD_W-1:0] s1_x_reg, s1_y_reg;
    logic [FRAC_BITS-1:0]        s1_fx_reg, s1_fy_reg;
    logic                        s1_px_reg, s1_py_reg;

    // Stage 2: weights and neighbour pixels
    logic                        s2_valid_reg;
    logic [bis_pkg::COORD_W-1:0] s2_x_reg, s2_y_reg;
    logic [WT_W-1:0]             s2_wt_reg [4];
    logic [WT_W-1:0]             s2_wt_next [4];
    logic [bis_pkg::PIX_W-1:0]   s2_pix_reg [4];
    logic [bis_pkg::PIX_W-1:0]   s2_pix_next [4];
    logic [FRAC_BITS:0]          gx0, gy0, gx1, gy1;

    // Stage 3: weighted pixels
    logic                        s3_valid_reg;
    logic [bis_pkg::COORD_W-1:0] s3_x_reg, s3_y_reg;
    logic [PR_W-1:0]             s3_prod_reg [4];
    logic [PR_W-1:0]             s3_prod_next [4];

    // Stage 4: pair sums
    logic                        s4_valid_reg;
    logic [bis_pkg::COORD_W-1:0] s4_x_reg, s4_y_reg;
    logic [SUM_W-1:0]            s4_ab_reg, s4_cd_reg;
    logic [SUM_W-1:0]            s4_ab_next, s4_cd_next;

    // Result register
    logic                        out_valid_reg;
    logic [bis_pkg::COORD_W-1:0] out_x_reg, out_y_reg;
    logic [bis_pkg::PIX_W-1:0]   out_value_reg;
    logic [SUM_W-1:0]            sum_next;
    logic [bis_pkg::PIX_W-1:0]   out_value_next;

    assign head_e = head;

    // Move the whole pipeline unless the result beat is held up
    assign adv = !out_valid_reg || results.ready;
    assign pop = adv && !q_empty;

    // Bank row/column halves: the even bank takes the odd neighbour's next slot
    assign rh0 = RH_W'(head_e.iy >> 1) + RH_W'(head_e.iy[0]);
    assign rh1 = RH_W'(head_e.iy >> 1);
    assign ch0 = CH_W'(head_e.ix >> 1) + CH_W'(head_e.ix[0]);
    assign ch1 = CH_W'(head_e.ix >> 1);

    assign bank_addr[0] = BANK_AW'(32'(rh0) * HALF_W + 32'(ch0));
    assign bank_addr[1] = BANK_AW'(32'(rh0) * HALF_W + 32'(ch1));
    assign bank_addr[2] = BANK_AW'(32'(rh1) * HALF_W + 32'(ch0));
    assign bank_addr[3] = BANK_AW'(32'(rh1) * HALF_W + 32'(ch1));

    assign bank_re = pop && head_e.is_sample;

    for (genvar k = 0; k < 4; k++)
    begin : g_bank
        assign bank_we[k] = pop && !head_e.is_sample
                            && ({head_e.iy[0], head_e.ix[0]} == 2'(k));

        bis_ram #(
            .WIDTH (bis_pkg::PIX_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we[k]),
            .re    (bank_re),
            .addr  (bank_addr[k]),
            .wdata (head_e.pixel),
            .rdata (rd_data[k])
        );
    end

    assign s1_valid_next = pop && head_e.is_sample;

    // Pick the neighbours out of the banks and form the weights
    always_comb
    begin
        gx1 = {1'b0, s1_fx_reg};
        gy1 = {1'b0, s1_fy_reg};
        gx0 = ONE - gx1;
        gy0 = ONE - gy1;
        s2_wt_next[0]  = WT_W'(gx0) * WT_W'(gy0);
        s2_wt_next[1]  = WT_W'(gx1) * WT_W'(gy0);
        s2_wt_next[2]  = WT_W'(gx0) * WT_W'(gy1);
        s2_wt_next[3]  = WT_W'(gx1) * WT_W'(gy1);
        s2_pix_next[0] = rd_data[{s1_py_reg, s1_px_reg}];
        s2_pix_next[1] = rd_data[{s1_py_reg, ~s1_px_reg}];
        s2_pix_next[2] = rd_data[{~s1_py_reg, s1_px_reg}];
        s2_pix_next[3] = rd_data[{~s1_py_reg, ~s1_px_reg}];
    end

    // Weight each neighbour
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            s3_prod_next[i] = PR_W'(s2_wt_reg[i]) * PR_W'(s2_pix_reg[i]);
        end
    end

    // Sum and keep the integer part
    assign s4_ab_next     = SUM_W'(s3_prod_reg[0]) + SUM_W'(s3_prod_reg[1]);
    assign s4_cd_next     = SUM_W'(s3_prod_reg[2]) + SUM_W'(s3_prod_reg[3]);
    assign sum_next       = s4_ab_reg + s4_cd_reg;
    assign out_value_next = sum_next[SHIFT+bis_pkg::PIX_W-1:SHIFT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    // Payload follows the valid bits
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg      <= head_e.pos_x;
            s1_y_reg      <= head_e.pos_y;
            s1_fx_reg     <= head_e.fx;
            s1_fy_reg     <= head_e.fy;
            s1_px_reg     <= head_e.ix[0];
            s1_py_reg     <= head_e.iy[0];
            s2_x_reg      <= s1_x_reg;
            s2_y_reg      <= s1_y_reg;
            s2_wt_reg     <= s2_wt_next;
            s2_pix_reg    <= s2_pix_next;
            s3_x_reg      <= s2_x_reg;
            s3_y_reg      <= s2_y_reg;
            s3_prod_reg   <= s3_prod_next;
            s4_x_reg      <= s3_x_reg;
            s4_y_reg      <= s3_y_reg;
            s4_ab_reg     <= s4_ab_next;
            s4_cd_reg     <= s4_cd_next;
            out_x_reg     <= s4_x_reg;
            out_y_reg     <= s4_y_reg;
            out_value_reg <= out_value_next;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.out_x     = out_x_reg;
    assign results.out_y     = out_y_reg;
    assign results.out_value = out_value_reg;

endmodule

// ===== src/bilinear_image_scaler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_scaler
// Frame store with bilinear resampling of destination pixels.
// ----------------------------------------------------------------------------
// Usage:
//   items   : valid/ready beats. kind = load writes pixel_in at (pos_x, pos_y);
//             kind = sample asks for destination pixel (pos_x, pos_y).
//   results : one beat per sample, in order: out_x, out_y, out_value.
//   APB     : src_width, src_height, h_ratio, v_ratio (Q9.16) at 0x0..0xC;
//             write them only while no item is in flight.
// Throughput: one item per cycle unless the queue is full or a result waits.
//   The four neighbours of a sample come from four row/column parity banks
//   of the frame store, one read each per cycle.
// Path: multiply, queue, bank read, weights, products, sums, result register.
// Reset: registers return to 256 x 256 and ratio 1.0, pipeline and queue
//   empty. The frame store is not cleared; load a pixel before sampling it.
// Stall: a held result freezes the back pipeline; a 4-entry queue keeps
//   taking beats until it fills, then items.ready falls.
// ----------------------------------------------------------------------------
module bilinear_image_scaler #(
    parameter int MAX_WIDTH  = bis_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bis_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = bis_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    bis_in_if.sink                       items,
    bis_out_if.source                    results,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bis_pkg::CFG_AW-1:0]   paddr,
    input  logic [bis_pkg::CFG_DW-1:0]   pwdata,
    output logic [bis_pkg::CFG_DW-1:0]   prdata,
    output logic                         pready
);

    localparam int ENTRY_W = bis_pkg::entry_width(MAX_WIDTH, MAX_HEIGHT, FRAC_BITS);

    bis_pkg::cfg_t      cfg;
    logic               q_push, q_pop, q_full, q_empty;
    logic [ENTRY_W-1:0] q_in, q_head;

    // Configuration registers
    bis_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Front: accept and position
    bis_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cfg       (cfg),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_in)
    );

    // Queue between front and back
    bis_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (bis_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back: store access and interpolation
    bis_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .head    (q_head),
        .pop     (q_pop),
        .results (results)
    );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bilinear image scaler. Load beats fill a
// shadow frame store and sample beats are predicted bilinearly against it,
// then compared in order with the result beats. Configuration goes through
// the APB port between phases, each write read back. Every sample only
// touches pixels that were loaded earlier. Both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import bis_pkg::*;

    localparam int ROW_STRIDE = MAX_WIDTH_DEF;
    localparam int FRAC       = FRAC_BITS_DEF;
    localparam longint unsigned ONE_FIX = 64'd1 << FRAC;

    typedef struct {
        logic                kind;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [PIX_W-1:0]    pix;
    } scaler_item_t;

    typedef struct {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [PIX_W-1:0]    value;
    } scaled_pixel_t;

    logic clk;
    logic rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [CFG_DW-1:0]   pwdata;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    bis_in_if  item_ch();
    bis_out_if result_ch();

    bilinear_image_scaler u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the block: configuration and frame store
    cfg_t         scaler_cfg;
    logic [7:0]   frame_mem [0:65535];
    bit           pixel_loaded [0:65535];

    scaler_item_t  pending_items[$];
    scaled_pixel_t expected_pixels[$];

    int  items_queued;
    int  samples_queued;
    int  mismatch_cnt;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  long_hold_seq;
    int  long_hold_seen;
    int  hold_left;
    bit  item_beat_taken;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Give up after a generous time
    initial
    begin
        #400_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void note_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%s", msg);
    endfunction

    function automatic int effective_size(input logic [SIZE_W-1:0] s, input int limit);
        int n;
        n = s;
        if (n < 2)
            n = 2;
        if (n > limit)
            n = limit;
        return n;
    endfunction

    // Top-left source cell and fractions of a destination pixel
    function automatic void locate_cell(input logic [COORD_W-1:0] x, y,
                                        output int ix, iy,
                                        output longint unsigned fx, fy);
        longint unsigned px, py;
        int w, h;
        w  = effective_size(scaler_cfg.src_width, MAX_WIDTH_DEF);
        h  = effective_size(scaler_cfg.src_height, MAX_HEIGHT_DEF);
        px = x;
        px = px * scaler_cfg.h_ratio;
        py = y;
        py = py * scaler_cfg.v_ratio;
        fx = px & (ONE_FIX - 1);
        fy = py & (ONE_FIX - 1);
        px = px >> FRAC;
        py = py >> FRAC;
        if (px + 1 >= w)
            px = w - 2;
        if (py + 1 >= h)
            py = h - 2;
        ix = int'(px);
        iy = int'(py);
    endfunction

    // Bilinear blend of the four neighbours, truncated
    function automatic scaled_pixel_t interpolate(input logic [COORD_W-1:0] x, y);
        int ix, iy;
        longint unsigned fx, fy, gx, gy, sum;
        longint unsigned a, b, c, d;
        scaled_pixel_t r;
        locate_cell(x, y, ix, iy, fx, fy);
        a   = frame_mem[iy * ROW_STRIDE + ix];
        b   = frame_mem[iy * ROW_STRIDE + ix + 1];
        c   = frame_mem[(iy + 1) * ROW_STRIDE + ix];
        d   = frame_mem[(iy + 1) * ROW_STRIDE + ix + 1];
        gx  = ONE_FIX - fx;
        gy  = ONE_FIX - fy;
        sum = gx * gy * a + fx * gy * b + gx * fy * c + fx * fy * d;
        r.x     = x;
        r.y     = y;
        r.value = PIX_W'(sum >> (2 * FRAC));
        return r;
    endfunction

    function automatic void queue_item(input logic kind, input logic [COORD_W-1:0] x, y,
                                       input logic [PIX_W-1:0] pix);
        scaler_item_t it;
        it.kind = kind;
        it.x    = x;
        it.y    = y;
        it.pix  = pix;
        pending_items.push_back(it);
        items_queued++;
        if (kind == KIND_LOAD)
            pixel_loaded[{y, x}] = 1'b1;
        else
            samples_queued++;
    endfunction

    // Load any missing neighbour first, then ask for the sample
    function automatic void queue_sample(input logic [COORD_W-1:0] x, y, input bit extremes);
        int ix, iy;
        longint unsigned fx, fy;
        logic [COORD_W-1:0] cx, cy;
        logic [PIX_W-1:0] pix;
        locate_cell(x, y, ix, iy, fx, fy);
        for (int dy = 0; dy < 2; dy++)
        begin
            for (int dx = 0; dx < 2; dx++)
            begin
                cx = COORD_W'(ix + dx);
                cy = COORD_W'(iy + dy);
                if (!pixel_loaded[{cy, cx}])
                begin
                    if (extremes)
                        pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    else
                        pix = PIX_W'($urandom_range(0, 255));
                    queue_item(KIND_LOAD, cx, cy, pix);
                end
            end
        end
        queue_item(KIND_SAMPLE, x, y, PIX_W'($urandom_range(0, 255)));
    endfunction

    // Random loads and samples, mostly inside a small window that gets reused
    task automatic queue_random(input int target);
        int goal, sample_goal, w, h;
        logic [COORD_W-1:0] x, y;
        goal        = items_queued + target;
        sample_goal = samples_queued + 20;
        w = effective_size(scaler_cfg.src_width, MAX_WIDTH_DEF);
        h = effective_size(scaler_cfg.src_height, MAX_HEIGHT_DEF);
        while (items_queued < goal || samples_queued < sample_goal)
        begin
            if ($urandom_range(0, 99) < 30)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    x = COORD_W'($urandom_range(0, 255));
                    y = COORD_W'($urandom_range(0, 255));
                end
                else
                begin
                    x = COORD_W'($urandom_range(0, ((w < 24) ? w : 24) - 1));
                    y = COORD_W'($urandom_range(0, ((h < 24) ? h : 24) - 1));
                end
                queue_item(KIND_LOAD, x, y, PIX_W'($urandom_range(0, 255)));
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    x = COORD_W'($urandom_range(0, 255));
                    y = COORD_W'($urandom_range(0, 255));
                end
                else
                begin
                    x = COORD_W'($urandom_range(0, 15));
                    y = COORD_W'($urandom_range(0, 15));
                end
                queue_sample(x, y, $urandom_range(0, 7) == 0);
            end
        end
    endtask

    // APB write, then read the register back
    task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DW-1:0] value);
        logic [CFG_DW-1:0] mask;
        logic [CFG_DW-1:0] kept;
        mask = (idx == REG_SRC_WIDTH || idx == REG_SRC_HEIGHT) ? 32'h0000_01FF : 32'h01FF_FFFF;
        kept = value & mask;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= kept | ($urandom() & ~mask);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_SRC_WIDTH:  scaler_cfg.src_width  = kept[SIZE_W-1:0];
            REG_SRC_HEIGHT: scaler_cfg.src_height = kept[SIZE_W-1:0];
            REG_H_RATIO:    scaler_cfg.h_ratio    = kept[RATIO_W-1:0];
            REG_V_RATIO:    scaler_cfg.v_ratio    = kept[RATIO_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== kept)
            note_mismatch($sformatf("register %0d read back: expected %h, got %h",
                                    idx, kept, prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Hold until nothing is queued, offered or awaited
    task automatic drain();
        while (pending_items.size() != 0 || item_ch.valid || expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Sender: hold a beat until taken, then offer the next one or idle
    always @(negedge clk)
    begin : drive_items
        scaler_item_t nxt;
        if (rst_n && (!item_ch.valid || item_beat_taken))
        begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = pending_items.pop_front();
                item_ch.valid    <= 1'b1;
                item_ch.kind     <= nxt.kind;
                item_ch.pos_x    <= nxt.x;
                item_ch.pos_y    <= nxt.y;
                item_ch.pixel_in <= nxt.pix;
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off when asked
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold_seq != long_hold_seen)
            begin
                long_hold_seen = long_hold_seq;
                hold_left      = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: absorb item beats, check result beats
    always @(posedge clk)
    begin : watch_beats
        scaled_pixel_t exp_px;
        item_beat_taken = rst_n && item_ch.valid && item_ch.ready;
        if (item_beat_taken)
        begin
            if (item_ch.kind == KIND_LOAD)
                frame_mem[{item_ch.pos_y, item_ch.pos_x}] = item_ch.pixel_in;
            else
                expected_pixels.push_back(interpolate(item_ch.pos_x, item_ch.pos_y));
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_pixels.size() == 0)
                note_mismatch($sformatf("unexpected result beat (%0d,%0d)=%0d",
                                        result_ch.out_x, result_ch.out_y,
                                        result_ch.out_value));
            else
            begin
                exp_px = expected_pixels.pop_front();
                if (result_ch.out_x !== exp_px.x || result_ch.out_y !== exp_px.y
                    || result_ch.out_value !== exp_px.value)
                    note_mismatch($sformatf("result: expected (%0d,%0d)=%0d, got (%0d,%0d)=%0d",
                                            exp_px.x, exp_px.y, exp_px.value,
                                            result_ch.out_x, result_ch.out_y,
                                            result_ch.out_value));
            end
        end
    end

    // Stimulus and phases
    initial
    begin
        logic [SIZE_W-1:0]  widths  [7];
        logic [SIZE_W-1:0]  heights [7];
        logic [RATIO_W-1:0] h_steps [7];
        logic [RATIO_W-1:0] v_steps [7];

        items_queued    = 0;
        samples_queued  = 0;
        mismatch_cnt    = 0;
        send_idle_pct   = 9;
        recv_idle_pct   = 61;
        long_hold_seq   = 0;
        long_hold_seen  = 0;
        hold_left       = 0;
        item_beat_taken = 1'b0;

        scaler_cfg.src_width  = SIZE_RST;
        scaler_cfg.src_height = SIZE_RST;
        scaler_cfg.h_ratio    = RATIO_RST;
        scaler_cfg.v_ratio    = RATIO_RST;

        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.kind      = KIND_LOAD;
        item_ch.pos_x     = '0;
        item_ch.pos_y     = '0;
        item_ch.pixel_in  = '0;
        result_ch.ready   = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;

        // Phase settings: reset values first, then extremes and typical scales
        widths[0] = SIZE_RST; heights[0] = SIZE_RST;
        h_steps[0] = RATIO_RST; v_steps[0] = RATIO_RST;
        widths[1] = 9'd0; heights[1] = 9'd1;
        h_steps[1] = 25'h1FF_FFFF; v_steps[1] = 25'd0;
        widths[2] = 9'd2; heights[2] = 9'd2;
        h_steps[2] = 25'h000_8000; v_steps[2] = 25'h100_0000;
        widths[3] = 9'd511; heights[3] = 9'd257;
        h_steps[3] = 25'h000_FFFF; v_steps[3] = 25'h001_0001;
        widths[4] = SIZE_W'($urandom_range(3, 64)); heights[4] = SIZE_W'($urandom_range(3, 64));
        h_steps[4] = RATIO_W'($urandom_range(0, 25'h3_FFFF));
        v_steps[4] = RATIO_W'($urandom_range(0, 25'h3_FFFF));
        widths[5] = 9'd40; heights[5] = 9'd30;
        h_steps[5] = RATIO_W'((40 << FRAC) / 100); v_steps[5] = RATIO_W'((30 << FRAC) / 90);
        widths[6] = 9'd256; heights[6] = 9'd256;
        h_steps[6] = RATIO_W'($urandom()); v_steps[6] = RATIO_W'($urandom());

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 7; ph++)
        begin
            // Reconfigure only once the block has gone quiet
            if (ph != 0)
            begin
                drain();
                repeat (10) @(posedge clk);
                cfg_write(REG_SRC_WIDTH, 32'(widths[ph]));
                cfg_write(REG_SRC_HEIGHT, 32'(heights[ph]));
                cfg_write(REG_H_RATIO, 32'(h_steps[ph]));
                cfg_write(REG_V_RATIO, 32'(v_steps[ph]));
            end

            if (ph < 3)
            begin
                send_idle_pct = 9;
                recv_idle_pct = 61;
            end
            else if (ph < 5)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 9;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // Corners at unity scale, right and bottom edges clamped
            if (ph == 0)
            begin
                queue_sample(8'd0, 8'd0, 1'b1);
                queue_sample(8'd255, 8'd255, 1'b1);
                queue_sample(8'd255, 8'd0, 1'b1);
                queue_sample(8'd0, 8'd255, 1'b1);
            end

            queue_random(70);

            // Stall the results long enough for the input to back up
            if (ph == 2)
                long_hold_seq++;
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
